@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define IIB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("iib assertion failed");

// checked at every rising edge, reset included
`define IIB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("iib assertion failed");

`endif

@@ hw/rtl/iib_pkg.sv @@
// constants, codes and types of the inverted index builder
package iib_pkg;

  localparam int unsigned WORD_SLOTS = 1024;
  localparam int unsigned LIST_DEPTH = 128;
  localparam int unsigned DOC_BITS   = 16;

  localparam int unsigned SLOT_W = $clog2(WORD_SLOTS);
  localparam int unsigned IDX_W  = $clog2(LIST_DEPTH);
  localparam int unsigned LEN_W  = IDX_W + 1;
  localparam int unsigned CNT_W  = $clog2(WORD_SLOTS + 1);
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;

  // port field widths
  localparam int unsigned WORD_FW   = 11;
  localparam int unsigned DOC_FW    = 16;
  localparam int unsigned POS_FW    = 7;
  localparam int unsigned STATUS_FW = 3;
  localparam int unsigned LEN_FW    = 8;
  localparam int unsigned CNT_FW    = 11;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [STATUS_FW-1:0] {
    ST_APPENDED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_WORD = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_BEYOND   = 3'd5
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    logic                kind;
    logic                bad;
    logic [SLOT_W-1:0]   slot;
    logic [DOC_BITS-1:0] doc;
    logic [POS_FW-1:0]   pos;
  } cmd_t;

endpackage

@@ hw/rtl/iib_if.sv @@
// request and result channel interfaces
interface iib_in_if;
  import iib_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [WORD_FW-1:0] word_number;
  logic [DOC_FW-1:0]  doc_number;
  logic [POS_FW-1:0]  entry_position;

  modport source (output valid, kind, word_number, doc_number, entry_position,
                  input ready);
  modport sink (input valid, kind, word_number, doc_number, entry_position,
                output ready);
endinterface

interface iib_out_if;
  import iib_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_FW-1:0] status;
  logic [LEN_FW-1:0]    list_length;
  logic [DOC_FW-1:0]    doc_out;
  logic                 first_sight;
  logic [CNT_FW-1:0]    distinct_words;

  modport source (output valid, status, list_length, doc_out, first_sight,
                  distinct_words, input ready);
  modport sink (input valid, status, list_length, doc_out, first_sight,
                distinct_words, output ready);
endinterface

@@ hw/rtl/iib_front.sv @@
// front end: takes requests and classifies the word number
module iib_front import iib_pkg::*; (
  iib_in_if.sink in_i,
  input  logic   clearing_i,
  input  logic   q_full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  logic bad;

  assign in_i.ready = !q_full_i && !clearing_i;
  assign push_o     = in_i.valid && in_i.ready;

  assign bad = (in_i.word_number == '0) ||
               (in_i.word_number > WORD_FW'(WORD_SLOTS));

  always_comb begin
    cmd_o.kind = in_i.kind;
    cmd_o.bad  = bad;
    // one-based word number to zero-based slot
    cmd_o.slot = SLOT_W'(in_i.word_number - WORD_FW'(1));
    cmd_o.doc  = DOC_BITS'(in_i.doc_number);
    cmd_o.pos  = in_i.entry_position;
  end

endmodule

@@ hw/rtl/iib_queue.sv @@
// two-entry queue of classified requests between front and back
module iib_queue import iib_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

@@ hw/rtl/iib_back.sv @@
// back end: length table, posting store, duplicate scan and result register
module iib_back import iib_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t head_i,
  output logic pop_o,
  output logic clearing_o,
  iib_out_if.source res_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RDW   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;
  cmd_t                cmd_q, cmd_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                vld_q, vld_d;
  status_e             status_q, status_d;
  logic [LEN_W-1:0]    rlen_q, rlen_d;
  logic [DOC_BITS-1:0] rdoc_q, rdoc_d;
  logic                first_q, first_d;

  // length table and posting store
  logic [LEN_W-1:0]    len_mem [WORD_SLOTS];
  logic [DOC_BITS-1:0] st_mem [WORD_SLOTS * LIST_DEPTH];
  logic [LEN_W-1:0]    len_rd_q;
  logic [DOC_BITS-1:0] st_rd_q;

  logic                len_re, len_we, st_re, st_we;
  logic [SLOT_W-1:0]   len_ra, len_wa;
  logic [LEN_W-1:0]    len_wd;
  logic [ADDR_W-1:0]   st_ra, st_wa;
  logic [LEN_W-1:0]    cur_len;
  logic                nf_done;

  assign clearing_o = (state_q == S_CLEAR);
  // the scan pass sees the length from the table in S_LEN, else the copy
  assign cur_len = (state_q == S_LEN) ? len_rd_q : len_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    vld_d    = vld_q;
    status_d = status_q;
    rlen_d   = rlen_q;
    rdoc_d   = rdoc_q;
    first_d  = first_q;
    pop_o    = 1'b0;
    len_re   = 1'b0;
    len_ra   = head_i.slot;
    len_we   = 1'b0;
    len_wa   = cmd_q.slot;
    len_wd   = cur_len + LEN_W'(1);
    st_re    = 1'b0;
    st_ra    = {cmd_q.slot, IDX_W'(0)};
    st_we    = 1'b0;
    st_wa    = {cmd_q.slot, cur_len[IDX_W-1:0]};
    nf_done  = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        len_we = 1'b1;
        len_wa = clr_q;
        len_wd = '0;
        clr_d  = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(WORD_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          first_d = 1'b0;
          if (head_i.bad) begin
            status_d = ST_BAD_WORD;
            rlen_d   = '0;
            rdoc_d   = '0;
            vld_d    = 1'b1;
            state_d  = S_RESP;
          end else begin
            len_re  = 1'b1;
            state_d = S_LEN;
          end
        end
      end
      S_LEN: begin
        len_d = len_rd_q;
        if (cmd_q.kind == KIND_ADD) begin
          // an empty list means the slot was never used
          if (len_rd_q == '0) begin
            first_d = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
            nf_done = 1'b1;
          end else begin
            st_re   = 1'b1;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end else if (LEN_W'(cmd_q.pos) < len_rd_q) begin
          st_re   = 1'b1;
          st_ra   = {cmd_q.slot, IDX_W'(cmd_q.pos)};
          state_d = S_RDW;
        end else begin
          status_d = ST_BEYOND;
          rlen_d   = len_rd_q;
          rdoc_d   = '0;
          vld_d    = 1'b1;
          state_d  = S_RESP;
        end
      end
      S_SCAN: begin
        if (st_rd_q == cmd_q.doc) begin
          status_d = ST_PRESENT;
          rlen_d   = len_q;
          rdoc_d   = '0;
          vld_d    = 1'b1;
          state_d  = S_RESP;
        end else if (LEN_W'(idx_q) + LEN_W'(1) == len_q) begin
          nf_done = 1'b1;
        end else begin
          // compare this entry while the next one is read
          idx_d = idx_q + IDX_W'(1);
          st_re = 1'b1;
          st_ra = {cmd_q.slot, idx_q + IDX_W'(1)};
        end
      end
      S_RDW: begin
        status_d = ST_READ_OK;
        rlen_d   = len_q;
        rdoc_d   = st_rd_q;
        vld_d    = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (res_o.ready) begin
          vld_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // document absent: append if there is room
    if (nf_done) begin
      rdoc_d  = '0;
      vld_d   = 1'b1;
      state_d = S_RESP;
      if (cur_len >= LEN_W'(LIST_DEPTH)) begin
        status_d = ST_FULL;
        rlen_d   = cur_len;
      end else begin
        status_d = ST_APPENDED;
        rlen_d   = cur_len + LEN_W'(1);
        st_we    = 1'b1;
        len_we   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    len_q    <= len_d;
    status_q <= status_d;
    rlen_q   <= rlen_d;
    rdoc_q   <= rdoc_d;
    first_q  <= first_d;
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_wa] <= cmd_q.doc;
    end
    if (st_re) begin
      st_rd_q <= st_mem[st_ra];
    end
  end

  assign res_o.valid          = vld_q;
  assign res_o.status         = status_q;
  assign res_o.list_length    = LEN_FW'(rlen_q);
  assign res_o.doc_out        = DOC_FW'(rdoc_q);
  assign res_o.first_sight    = first_q;
  assign res_o.distinct_words = CNT_FW'(cnt_q);

endmodule

@@ hw/rtl/inverted_index_builder_top.sv @@
// Inverted index builder: posting lists of documents per word.
// in_i carries requests: kind 0 adds doc_number to the list of word_number,
// kind 1 reads entry entry_position of that list. word_number is one-based.
// out_o carries one result per request: status, list length, the document
// read, a first-sight flag and the count of distinct words so far.
// After reset the length table (1024 entries) is cleared one entry per cycle;
// in_i.ready stays low until that clear is done.
// A front stage classifies requests into a two-entry queue; the back end
// serves one request at a time. A bad word skips the tables; any other
// request first reads the length table. A valid read then reads one entry
// of the posting store; an add that scans k entries of the list (k up to
// 128) makes one posting store read per cycle. The back end pops the next
// request only after the result of the last one has been taken.
// Results sit in an output register; while out_o.ready is low the back end
// holds, and the queue still takes up to two more requests.
`include "assert_macros.svh"

module inverted_index_builder_top import iib_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  iib_in_if.sink     in_i,
  iib_out_if.source  out_o
);

  logic clearing, q_full, q_empty, push, pop;
  cmd_t cmd, head;

  iib_front u_front (
    .in_i       (in_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  iib_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  iib_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (out_o)
  );

  `IIB_ASSERT(a_len_bound, out_o.valid |-> out_o.list_length <= LEN_FW'(LIST_DEPTH))
  `IIB_ASSERT(a_first_appends, (out_o.valid && out_o.first_sight) |-> (out_o.status == ST_APPENDED && out_o.list_length == LEN_FW'(1)))
  `IIB_ASSERT(a_doc_only_read, (out_o.valid && out_o.status != ST_READ_OK) |-> out_o.doc_out == '0)
  `IIB_ASSERT(a_no_pop_empty, pop |-> !q_empty)
  `IIB_ASSERT_ALWAYS(a_no_accept_reset, !rst_ni |-> !in_i.ready)

endmodule
